FILE: hw/rtl/tcpq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcpq_pkg
// Shared types and codes for the two-class strict-priority queue: operation
// and status codes, and the command and status groups between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package tcpq_pkg;

    // width of the value and removed-value fields
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;

    // request operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // class select on insert
    localparam logic CLASS_HIGH = 1'b1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_OVERFLOW  = 3'd1,
        ST_FROM_HIGH = 3'd2,
        ST_FROM_LOW  = 3'd3,
        ST_EMPTY     = 3'd4
    } t_status;

    // controller states
    typedef enum logic {
        S_IDLE,
        S_REPLY
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic    load;
        logic    push_high;
        logic    push_low;
        logic    pop_high;
        logic    pop_low;
        t_status status;
    } t_cmd;

    // ring occupancy flags from datapath to controller
    typedef struct packed {
        logic high_full;
        logic low_full;
        logic high_empty;
        logic low_empty;
    } t_stat;

endpackage
`default_nettype wire

FILE: hw/rtl/tcpq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcpq_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module tcpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: hw/rtl/tcpq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcpq_ctrl
// Request controller: accepts a request, picks the ring operation from the
// opcode, class and ring occupancy, and strobes the result in the next cycle.
// ----------------------------------------------------------------------------
module tcpq_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic           i_op,
    input  wire logic           i_high_class,
    input  wire tcpq_pkg::t_stat i_stat,
    output tcpq_pkg::t_cmd      o_cmd,
    output logic                o_busy,
    output logic                o_valid
);

    tcpq_pkg::t_state r_state;
    tcpq_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcpq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.status     = tcpq_pkg::ST_EMPTY;
        o_busy           = 1'b0;
        o_valid          = 1'b0;
        case (r_state)
            tcpq_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = tcpq_pkg::S_REPLY;
                    if (i_op == tcpq_pkg::OP_INSERT) begin
                        if (i_high_class == tcpq_pkg::CLASS_HIGH) begin
                            if (i_stat.high_full) begin
                                o_cmd.status = tcpq_pkg::ST_OVERFLOW;
                            end else begin
                                o_cmd.push_high = 1'b1;
                                o_cmd.status    = tcpq_pkg::ST_INSERTED;
                            end
                        end else begin
                            if (i_stat.low_full) begin
                                o_cmd.status = tcpq_pkg::ST_OVERFLOW;
                            end else begin
                                o_cmd.push_low = 1'b1;
                                o_cmd.status   = tcpq_pkg::ST_INSERTED;
                            end
                        end
                    end else if (!i_stat.high_empty) begin
                        o_cmd.pop_high = 1'b1;
                        o_cmd.status   = tcpq_pkg::ST_FROM_HIGH;
                    end else if (!i_stat.low_empty) begin
                        o_cmd.pop_low = 1'b1;
                        o_cmd.status  = tcpq_pkg::ST_FROM_LOW;
                    end else begin
                        o_cmd.status = tcpq_pkg::ST_EMPTY;
                    end
                end
            end
            tcpq_pkg::S_REPLY: begin
                o_busy  = 1'b1;
                o_valid = 1'b1;
                n_state = tcpq_pkg::S_IDLE;
            end
            default: begin
                n_state = tcpq_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: hw/rtl/tcpq_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcpq_dpath
// Ring datapath: the two element stores, their head, tail and count
// registers, and the result status and removed-value output.
// ----------------------------------------------------------------------------
module tcpq_dpath #(
    parameter int DEPTH      = 32,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire tcpq_pkg::t_cmd                  i_cmd,
    input  wire logic [tcpq_pkg::VALUE_W-1:0]    i_value,
    output tcpq_pkg::t_stat                      o_stat,
    output logic      [tcpq_pkg::STATUS_W-1:0]   o_status,
    output logic      [tcpq_pkg::VALUE_W-1:0]    o_removed_value
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int EXT_W = (DATA_WIDTH > tcpq_pkg::VALUE_W) ? DATA_WIDTH : tcpq_pkg::VALUE_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [PTR_W-1:0] r_high_head;
    logic [PTR_W-1:0] r_high_tail;
    logic [CNT_W-1:0] r_high_count;
    logic [PTR_W-1:0] r_low_head;
    logic [PTR_W-1:0] r_low_tail;
    logic [CNT_W-1:0] r_low_count;
    tcpq_pkg::t_status r_status;

    logic [EXT_W-1:0]      wide_value;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [DATA_WIDTH-1:0] high_rdata;
    logic [DATA_WIDTH-1:0] low_rdata;
    logic [DATA_WIDTH-1:0] sel_rdata;
    logic [tcpq_pkg::VALUE_W-1:0] ext_rdata;

    // wrap-around increment
    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
        ptr_next = (ptr == PTR_LAST) ? '0 : ptr + 1'b1;
    endfunction

    // occupancy flags
    assign o_stat.high_full  = (r_high_count == CNT_FULL);
    assign o_stat.low_full   = (r_low_count == CNT_FULL);
    assign o_stat.high_empty = (r_high_count == '0);
    assign o_stat.low_empty  = (r_low_count == '0);

    // stored element: low bits of the value, zero-extended for wide stores
    assign wide_value = EXT_W'(i_value);
    assign wr_data    = wide_value[DATA_WIDTH-1:0];

    // high ring pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_head  <= '0;
            r_high_tail  <= '0;
            r_high_count <= '0;
        end else if (i_cmd.push_high) begin
            r_high_tail  <= ptr_next(r_high_tail);
            r_high_count <= r_high_count + 1'b1;
        end else if (i_cmd.pop_high) begin
            r_high_head  <= ptr_next(r_high_head);
            r_high_count <= r_high_count - 1'b1;
        end
    end

    // low ring pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_head  <= '0;
            r_low_tail  <= '0;
            r_low_count <= '0;
        end else if (i_cmd.push_low) begin
            r_low_tail  <= ptr_next(r_low_tail);
            r_low_count <= r_low_count + 1'b1;
        end else if (i_cmd.pop_low) begin
            r_low_head  <= ptr_next(r_low_head);
            r_low_count <= r_low_count - 1'b1;
        end
    end

    // result status register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_status <= i_cmd.status;
        end
    end

    // element stores
    tcpq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_high_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push_high),
        .i_waddr (r_high_tail),
        .i_wdata (wr_data),
        .i_re    (i_cmd.pop_high),
        .i_raddr (r_high_head),
        .o_rdata (high_rdata)
    );

    tcpq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_low_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push_low),
        .i_waddr (r_low_tail),
        .i_wdata (wr_data),
        .i_re    (i_cmd.pop_low),
        .i_raddr (r_low_head),
        .o_rdata (low_rdata)
    );

    // pick the ring that was popped
    assign sel_rdata = (r_status == tcpq_pkg::ST_FROM_HIGH) ? high_rdata : low_rdata;

    // sign-extend the stored element to the output width
    for (genvar gi = 0; gi < tcpq_pkg::VALUE_W; gi++) begin : g_ext
        if (gi < DATA_WIDTH) begin : g_bit
            assign ext_rdata[gi] = sel_rdata[gi];
        end else begin : g_sign
            assign ext_rdata[gi] = sel_rdata[DATA_WIDTH-1];
        end
    end

    // result outputs
    assign o_status        = r_status;
    assign o_removed_value = (r_status == tcpq_pkg::ST_FROM_HIGH ||
                              r_status == tcpq_pkg::ST_FROM_LOW) ? ext_rdata : '0;

endmodule
`default_nettype wire

FILE: hw/rtl/two_class_priority_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// two_class_priority_queue
// Two FIFO rings, high and low priority, behind one request port. Inserts
// go to the ring named by the class bit; removes pop high before low.
// ----------------------------------------------------------------------------
// the result is strobed in the cycle after the request is accepted
// no new request is taken while busy; busy covers the reply cycle,
//   in which the registered store read is presented
// the result is shown for one cycle only; the receiver cannot stall it
// reset clears heads, tails and counts; store contents stay undefined and
//   need no clearing pass
module two_class_priority_queue #(
    parameter int DEPTH      = 32,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_op,
    input  wire logic [tcpq_pkg::VALUE_W-1:0]  i_value,
    input  wire logic                          i_high_class,
    output logic                               o_valid,
    output logic      [tcpq_pkg::STATUS_W-1:0] o_status,
    output logic      [tcpq_pkg::VALUE_W-1:0]  o_removed_value
);

    tcpq_pkg::t_cmd  cmd;
    tcpq_pkg::t_stat stat;
    logic            ctrl_busy;
    logic            ctrl_valid;

    // request controller
    tcpq_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_op         (i_op),
        .i_high_class (i_high_class),
        .i_stat       (stat),
        .o_cmd        (cmd),
        .o_busy       (ctrl_busy),
        .o_valid      (ctrl_valid)
    );

    // rings and result datapath
    tcpq_dpath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_value         (i_value),
        .o_stat          (stat),
        .o_status        (o_status),
        .o_removed_value (o_removed_value)
    );

    assign busy    = ctrl_busy;
    assign o_valid = ctrl_valid;

    // an accepted request is answered in the next cycle
    a_reply_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_valid)
        else $error("no result after accepted request");

    // one result per request
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    // nothing removed means a zero value
    a_zero_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == tcpq_pkg::ST_EMPTY || o_status == tcpq_pkg::ST_INSERTED ||
                     o_status == tcpq_pkg::ST_OVERFLOW)) |-> (o_removed_value == '0))
        else $error("nonzero removed value without a removal");

endmodule
`default_nettype wire

FILE: tb/tcpq_reply_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tcpq_reply_checker
// Watches the request and reply ports of the two-class priority queue,
// keeps its own high and low rings, predicts the status and removed value
// of every accepted request and compares each reply against the oldest
// prediction. Reports the running failure count and the number of replies
// still outstanding.
// ----------------------------------------------------------------------------
module tcpq_reply_checker
    import tcpq_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic               i_busy,
    input  wire logic               i_op,
    input  wire logic [VALUE_W-1:0] i_value,
    input  wire logic               i_high_class,
    input  wire logic               i_valid,
    input  wire logic [STATUS_W-1:0] i_status,
    input  wire logic [VALUE_W-1:0] i_removed_value,
    output int                      o_fail_count,
    output int                      o_pending
);

    localparam int RING_DEPTH = 32;

    typedef struct {
        t_status              status;
        logic [VALUE_W-1:0]   removed;
    } t_reply;

    // model rings, indices wrap at RING_DEPTH
    logic [VALUE_W-1:0] high_ring [RING_DEPTH];
    logic [VALUE_W-1:0] low_ring  [RING_DEPTH];
    int high_rd, high_wr, high_used;
    int low_rd, low_wr, low_used;

    t_reply replies_due [$];
    int     mismatches;

    // apply one request to the model rings and return the reply it earns
    function automatic t_reply predict_reply(logic op, logic [VALUE_W-1:0] value,
                                             logic high_class);
        t_reply r;
        r.status  = ST_INSERTED;
        r.removed = '0;
        if (op == OP_INSERT) begin
            if (high_class == CLASS_HIGH) begin
                if (high_used == RING_DEPTH) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    high_ring[high_wr] = value;
                    high_wr   = (high_wr + 1) % RING_DEPTH;
                    high_used = high_used + 1;
                end
            end else begin
                if (low_used == RING_DEPTH) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    low_ring[low_wr] = value;
                    low_wr   = (low_wr + 1) % RING_DEPTH;
                    low_used = low_used + 1;
                end
            end
        end else if (high_used != 0) begin
            r.status  = ST_FROM_HIGH;
            r.removed = high_ring[high_rd];
            high_rd   = (high_rd + 1) % RING_DEPTH;
            high_used = high_used - 1;
        end else if (low_used != 0) begin
            r.status  = ST_FROM_LOW;
            r.removed = low_ring[low_rd];
            low_rd    = (low_rd + 1) % RING_DEPTH;
            low_used  = low_used - 1;
        end else begin
            r.status = ST_EMPTY;
        end
        return r;
    endfunction

    initial begin
        mismatches = 0;
    end

    // compare replies, then predict the request taken at this edge
    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            high_rd   = 0;
            high_wr   = 0;
            high_used = 0;
            low_rd    = 0;
            low_wr    = 0;
            low_used  = 0;
            replies_due.delete();
        end else begin
            if (i_valid) begin
                if (replies_due.size() == 0) begin
                    $error("reply with no request outstanding: status %0d value %0d",
                           i_status, $signed(i_removed_value));
                    mismatches++;
                end else begin
                    want = replies_due.pop_front();
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, i_status);
                        mismatches++;
                    end
                    if (i_removed_value !== want.removed) begin
                        $error("removed_value: expected %0d, actual %0d",
                               $signed(want.removed), $signed(i_removed_value));
                        mismatches++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                replies_due.push_back(predict_reply(i_op, i_value, i_high_class));
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= replies_due.size();
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives insert and remove requests into the two-class priority queue:
// a short directed pass over empty removes and extreme values, then bursts
// that fill rings to overflow and drain them to empty, under several sender
// idle rates. The checker beside the block judges every reply.
// ----------------------------------------------------------------------------
module tb_top;
    import tcpq_pkg::*;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic                req_op;
    logic [VALUE_W-1:0]  req_value;
    logic                req_high;
    logic                rsp_valid;
    logic [STATUS_W-1:0] rsp_status;
    logic [VALUE_W-1:0]  rsp_value;

    int fail_count;
    int pending;
    int idle_pct;

    two_class_priority_queue dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (req_op),
        .i_value        (req_value),
        .i_high_class   (req_high),
        .o_valid        (rsp_valid),
        .o_status       (rsp_status),
        .o_removed_value(rsp_value)
    );

    tcpq_reply_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_op           (req_op),
        .i_value        (req_value),
        .i_high_class   (req_high),
        .i_valid        (rsp_valid),
        .i_status       (rsp_status),
        .i_removed_value(rsp_value),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // 2 ns clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // run limit
    initial begin
        #1_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    // present one request after an optional idle gap, return once taken
    task automatic issue(logic op, logic [VALUE_W-1:0] value, logic high_class);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start     <= 1'b1;
        req_op    <= op;
        req_value <= value;
        req_high  <= high_class;
        do @(posedge i_clk); while (busy);
    endtask

    // drop start and wait until every reply has come back
    task automatic drain_replies();
        int guard;
        start <= 1'b0;
        @(posedge i_clk);
        for (guard = 0; guard < 1000 && pending != 0; guard++) @(posedge i_clk);
    endtask

    // random value, with the extremes mixed in
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // bursts leaning to insert or to remove, so rings reach full and empty
    task automatic run_bursts(int n_items);
        int done;
        int len;
        int insert_pct;
        int high_pct;
        int k;
        done = 0;
        while (done < n_items) begin
            len = $urandom_range(48, 1);
            case ($urandom_range(2))
                0:       insert_pct = 90;
                1:       insert_pct = 50;
                default: insert_pct = 12;
            endcase
            high_pct = $urandom_range(100);
            for (k = 0; k < len && done < n_items; k++) begin
                if ($urandom_range(99) < insert_pct) begin
                    issue(OP_INSERT, pick_value(),
                          ($urandom_range(99) < high_pct) ? CLASS_HIGH : ~CLASS_HIGH);
                end else begin
                    issue(OP_REMOVE, $urandom, 1'($urandom_range(1)));
                end
                done++;
            end
        end
    endtask

    // stimulus and verdict
    initial begin
        i_rst_n   <= 1'b0;
        start     <= 1'b0;
        req_op    <= OP_INSERT;
        req_value <= '0;
        req_high  <= 1'b0;
        idle_pct  = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // remove from both empty rings, extremes into each class, drain all
        issue(OP_REMOVE, 32'h1234_5678, CLASS_HIGH);
        issue(OP_INSERT, 32'h8000_0000, ~CLASS_HIGH);
        issue(OP_INSERT, 32'h7fff_ffff, ~CLASS_HIGH);
        issue(OP_INSERT, 32'h0000_0000, CLASS_HIGH);
        issue(OP_INSERT, 32'hffff_ffff, CLASS_HIGH);
        issue(OP_INSERT, 32'h8000_0000, CLASS_HIGH);
        issue(OP_INSERT, 32'h7fff_ffff, CLASS_HIGH);
        issue(OP_INSERT, 32'h0000_0000, ~CLASS_HIGH);
        issue(OP_INSERT, 32'hffff_ffff, ~CLASS_HIGH);
        repeat (9) issue(OP_REMOVE, 32'hffff_ffff, ~CLASS_HIGH);

        // random phases: no idling, heavy idling, light idling, none again
        run_bursts(300);
        idle_pct = 80;
        run_bursts(250);
        drain_replies();
        idle_pct = 9;
        run_bursts(300);
        idle_pct = 0;
        run_bursts(300);

        drain_replies();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

FILE: two_class_priority_queue.f
hw/rtl/tcpq_pkg.sv
hw/rtl/tcpq_ram.sv
hw/rtl/tcpq_ctrl.sv
hw/rtl/tcpq_dpath.sv
hw/rtl/two_class_priority_queue.sv
tb/tcpq_reply_checker.sv
tb/tb_top.sv
